/* rtl/ptr_pkg.sv */
// Package for the palette texture resampler: operation codes, palette formats,
// register indexes and the sequencer state type. No dependencies.
`default_nettype none
package ptr_pkg;
  localparam logic [1:0] OP_PAL_WR   = 2'd0;
  localparam logic [1:0] OP_TEX_WR   = 2'd1;
  localparam logic [1:0] OP_FETCH    = 2'd2;

  localparam logic [1:0] FMT_NORMAL   = 2'd0;
  localparam logic [1:0] FMT_ADDITIVE = 2'd1;
  localparam logic [1:0] FMT_IDX_ALPHA = 2'd2;
  localparam logic [1:0] FMT_ALPHA_TEST = 2'd3;

  localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [1:0] REG_PAL_FORMAT = 2'd2;

  localparam logic [7:0] KEY_INDEX = 8'hFF;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_READ  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;
endpackage
`default_nettype wire

/* rtl/ptr_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module ptr_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

/* rtl/palette_texture_resample.sv */
// Top level of the palette texture resampler: texel and palette memories,
// fetch sequencer, accumulator and output register. Uses ptr_pkg and ptr_ram.
//
//  channel | direction | handshake           | payload
//  in      | to block  | in_valid_i/stall_o  | operation_i .. fetch_y_i
//  out     | from block| out_valid_o/stall_i | pixel_*_o, output_*_o, fetch_valid_o
//  cfg     | to block  | cfg_we_i            | cfg_index_i, cfg_data_i
//
// Write items can follow back to back while no fetch is in progress. Sample
// coordinates are registered at the fetch accept. A fetch then forms the four
// texel addresses, makes four texel reads through the single texel port, each
// chained into the palette port, empties that pipeline and publishes; a fetch
// outside the output skips the reads. The next item is accepted only after the
// result is published.
// Reset clears control state only; both memories are undefined until written.
// A held result stalls the next fetch only at its completion; writes keep flowing.
`default_nettype none
module palette_texture_resample #(
  parameter int MaxSourceDim = 256,
  parameter int MaxOutputDim = 256
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [8:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] operation_i,
  input  wire logic [7:0] palette_index_i,
  input  wire logic [7:0] entry_red_i,
  input  wire logic [7:0] entry_green_i,
  input  wire logic [7:0] entry_blue_i,
  input  wire logic [15:0] texel_address_i,
  input  wire logic [7:0] texel_index_i,
  input  wire logic [7:0] fetch_x_i,
  input  wire logic [7:0] fetch_y_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      pixel_red_o,
  output logic [7:0]      pixel_green_o,
  output logic [7:0]      pixel_blue_o,
  output logic [7:0]      pixel_alpha_o,
  output logic [8:0]      output_width_o,
  output logic [8:0]      output_height_o,
  output logic            fetch_valid_o
);
  import ptr_pkg::*;

  logic [8:0] src_w_q, src_h_q;
  logic [1:0] fmt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= 9'd16;
      src_h_q <= 9'd16;
      fmt_q   <= FMT_NORMAL;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SRC_WIDTH:  src_w_q <= cfg_data_i;
        REG_SRC_HEIGHT: src_h_q <= cfg_data_i;
        REG_PAL_FORMAT: fmt_q   <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Clamped source size and power-of-two output size (log2 form).
  logic [10:0] w_c, h_c;
  logic [3:0]  ow_log, oh_log;
  localparam int MaxOutLog = $clog2(MaxOutputDim);

  function automatic logic [10:0] clamp_src(input logic [8:0] v);
    logic [10:0] r;
    r = {2'b0, v};
    if (v == 9'd0) r = 11'd1;
    else if (r > 11'(MaxSourceDim)) r = 11'(MaxSourceDim);
    return r;
  endfunction

  function automatic logic [3:0] out_log(input logic [10:0] s);
    logic [3:0] l;
    l = 4'd0;
    for (int i = 10; i >= 0; i--) begin
      if ((11'd1 << i) >= s) l = 4'(i);
    end
    if (int'(l) > MaxOutLog) l = 4'(MaxOutLog);
    return l;
  endfunction

  assign w_c = clamp_src(src_w_q);
  assign h_c = clamp_src(src_h_q);
  assign ow_log = out_log(w_c);
  assign oh_log = out_log(h_c);

  logic [10:0] ow, oh;
  assign ow = 11'd1 << ow_log;
  assign oh = 11'd1 << oh_log;

  state_e state_q, state_d;
  logic [2:0] cnt_q;
  logic [15:0] addr_q [4];
  logic [9:0]  acc_r_q, acc_g_q, acc_b_q, acc_a_q;
  logic [10:0] c1_q, c2_q, r1_q, r2_q;
  logic        fv_q;

  logic in_acc;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc = in_valid_i && !in_stall_o;

  // Sample coordinates: ((4x+k)*w) >> (ow_log+2), taken from the incoming item.
  logic [20:0] c1p, c2p, r1p, r2p;
  logic [10:0] c1, c2, r1, r2;
  assign c1p = 21'({fetch_x_i, 2'b01}) * 21'(w_c);
  assign c2p = 21'({fetch_x_i, 2'b11}) * 21'(w_c);
  assign r1p = 21'({fetch_y_i, 2'b01}) * 21'(h_c);
  assign r2p = 21'({fetch_y_i, 2'b11}) * 21'(h_c);
  assign c1 = 11'(c1p >> (ow_log + 4'd2));
  assign c2 = 11'(c2p >> (ow_log + 4'd2));
  assign r1 = 11'(r1p >> (oh_log + 4'd2));
  assign r2 = 11'(r2p >> (oh_log + 4'd2));

  // Texel memory read address and palette memory chained from it.
  logic        tex_we, pal_we;
  logic [15:0] tex_addr;
  logic [7:0]  tex_rd, pal_addr, idx_q;
  logic [23:0] pal_rd;
  logic        idx_v_q, pal_v_q;

  assign tex_we   = in_acc && operation_i == OP_TEX_WR;
  assign pal_we   = in_acc && operation_i == OP_PAL_WR;
  assign tex_addr = tex_we ? texel_address_i : addr_q[cnt_q[1:0]];
  assign pal_addr = pal_we ? palette_index_i : tex_rd;

  ptr_ram #(.Width(8), .Depth(65536)) u_tex (
    .clk_i, .we_i(tex_we), .addr_i(tex_addr), .wdata_i(texel_index_i), .rdata_o(tex_rd)
  );
  ptr_ram #(.Width(24), .Depth(256)) u_pal (
    .clk_i, .we_i(pal_we), .addr_i(pal_addr),
    .wdata_i({entry_blue_i, entry_green_i, entry_red_i}), .rdata_o(pal_rd)
  );

  logic reading, publish;
  assign reading = (state_q == ST_READ);
  // Publish once the last palette read is in and the output register is free.
  assign publish = (state_q == ST_DRAIN) && !idx_v_q && !pal_v_q &&
                   !(out_valid_o && out_stall_i);

  // Expanded texel.
  logic [7:0] er, eg, eb, ea;
  always_comb begin
    er = pal_rd[7:0];
    eg = pal_rd[15:8];
    eb = pal_rd[23:16];
    ea = 8'hFF;
    if (fmt_q == FMT_IDX_ALPHA) begin
      ea = idx_q;
    end else if (fmt_q == FMT_ALPHA_TEST && idx_q == KEY_INDEX) begin
      er = '0; eg = '0; eb = '0; ea = '0;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_acc && operation_i == OP_FETCH) state_d = ST_DONE;
      ST_DONE:  state_d = fv_q ? ST_READ : ST_DRAIN;
      ST_READ:  if (cnt_q == 3'd3) state_d = ST_DRAIN;
      ST_DRAIN: if (publish) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      idx_v_q     <= 1'b0;
      pal_v_q     <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_v_q <= reading;
      pal_v_q <= idx_v_q;
      if (state_q == ST_DONE) cnt_q <= '0;
      else if (reading) cnt_q <= cnt_q + 3'd1;
      out_valid_o <= publish || (out_valid_o && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && operation_i == OP_FETCH) begin
      c1_q <= c1;
      c2_q <= c2;
      r1_q <= r1;
      r2_q <= r2;
      fv_q <= (11'(fetch_x_i) < ow) && (11'(fetch_y_i) < oh);
      acc_r_q <= '0; acc_g_q <= '0; acc_b_q <= '0; acc_a_q <= '0;
    end
    // Raster addresses wrap at the texel store depth.
    if (state_q == ST_DONE) begin
      addr_q[0] <= 16'(r1_q) * 16'(w_c) + 16'(c1_q);
      addr_q[1] <= 16'(r1_q) * 16'(w_c) + 16'(c2_q);
      addr_q[2] <= 16'(r2_q) * 16'(w_c) + 16'(c1_q);
      addr_q[3] <= 16'(r2_q) * 16'(w_c) + 16'(c2_q);
    end
    idx_q <= tex_rd;
    if (pal_v_q) begin
      acc_r_q <= acc_r_q + 10'(er);
      acc_g_q <= acc_g_q + 10'(eg);
      acc_b_q <= acc_b_q + 10'(eb);
      acc_a_q <= acc_a_q + 10'(ea);
    end
    if (publish) begin
      pixel_red_o     <= fv_q ? acc_r_q[9:2] : '0;
      pixel_green_o   <= fv_q ? acc_g_q[9:2] : '0;
      pixel_blue_o    <= fv_q ? acc_b_q[9:2] : '0;
      pixel_alpha_o   <= fv_q ? acc_a_q[9:2] : '0;
      output_width_o  <= ow[8:0];
      output_height_o <= oh[8:0];
      fetch_valid_o   <= fv_q;
    end
  end

  // idx_q is used by palette stage: align to the palette data cycle.
  // (tex_rd registered once more matches the pal_rd latency.)

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pal_v_q |-> $past(idx_v_q)) else $error("palette stage without texel read");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    reading |-> !tex_we) else $error("texel write during fetch reads");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> cnt_q < 3'd4) else $error("read counter overrun");
endmodule
`default_nettype wire

/* verif/tb_palette_texture_resample.sv */
// Testbench for palette_texture_resample: a scoreboard class mirrors the palette,
// texel store and registers, predicts each fetched pixel and checks results in order.
// Depends on ptr_pkg and the block's RTL.
`timescale 1ns / 100ps
module tb_palette_texture_resample;
  import ptr_pkg::*;

  localparam logic [1:0] OP_NONE  = 2'd3;
  localparam logic [1:0] REG_NONE = 2'd3;
  localparam int MAX_DIM = 256;

  typedef struct {
    logic [1:0]  op;
    logic [7:0]  pal_idx;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] tex_addr;
    logic [7:0]  tex_idx;
    logic [7:0]  fx;
    logic [7:0]  fy;
  } item_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [8:0] out_w;
    logic [8:0] out_h;
    logic       valid;
  } pixel_t;

  class pixel_scoreboard;
    logic [23:0] palette [256];
    bit          pal_written [256];
    logic [7:0]  texels [65536];
    bit          tex_written [65536];
    logic [8:0]  src_w;
    logic [8:0]  src_h;
    logic [1:0]  fmt;
    pixel_t      pending [$];
    int          errors;
    int          checked;
    int          fetches;
    int          writes;

    function new();
      src_w = 9'd16;
      src_h = 9'd16;
      fmt = FMT_NORMAL;
    endfunction

    function int clamp_dim(logic [8:0] v);
      if (v < 1) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
    endfunction

    function int pow2_dim(int s);
      int o;
      o = 1;
      while (o < s) o = o << 1;
      return (o > MAX_DIM) ? MAX_DIM : o;
    endfunction

    function void set_reg(logic [1:0] idx, logic [8:0] data);
      case (idx)
        REG_SRC_WIDTH:  src_w = data;
        REG_SRC_HEIGHT: src_h = data;
        REG_PAL_FORMAT: fmt = data[1:0];
        default: ;
      endcase
    endfunction

    // Addresses of the four taps; -1 when the fetch lies outside the output.
    function void tap_addrs(logic [7:0] x, logic [7:0] y, output int a [4]);
      int w, h, ow, oh, c1, c2, r1, r2;
      w = clamp_dim(src_w);
      h = clamp_dim(src_h);
      ow = pow2_dim(w);
      oh = pow2_dim(h);
      if (x >= ow || y >= oh) begin
        foreach (a[i]) a[i] = -1;
        return;
      end
      c1 = ((4 * x + 1) * w) / (4 * ow);
      c2 = ((4 * x + 3) * w) / (4 * ow);
      r1 = ((4 * y + 1) * h) / (4 * oh);
      r2 = ((4 * y + 3) * h) / (4 * oh);
      a[0] = (r1 * w + c1) % 65536;
      a[1] = (r1 * w + c2) % 65536;
      a[2] = (r2 * w + c1) % 65536;
      a[3] = (r2 * w + c2) % 65536;
    endfunction

    function pixel_t resample(logic [7:0] x, logic [7:0] y);
      pixel_t p;
      int a [4];
      int sum [4];
      logic [7:0] idx;
      logic [23:0] rgb;
      logic [7:0] alpha;
      p = '{default: '0};
      p.out_w = pow2_dim(clamp_dim(src_w));
      p.out_h = pow2_dim(clamp_dim(src_h));
      tap_addrs(x, y, a);
      if (a[0] < 0) return p;
      foreach (sum[i]) sum[i] = 0;
      foreach (a[k]) begin
        idx = texels[a[k]];
        rgb = palette[idx];
        alpha = 8'hFF;
        if (fmt == FMT_IDX_ALPHA) alpha = idx;
        else if (fmt == FMT_ALPHA_TEST && idx == KEY_INDEX) begin
          rgb = '0;
          alpha = '0;
        end
        sum[0] += rgb[7:0];
        sum[1] += rgb[15:8];
        sum[2] += rgb[23:16];
        sum[3] += alpha;
      end
      p.red = sum[0] >> 2;
      p.green = sum[1] >> 2;
      p.blue = sum[2] >> 2;
      p.alpha = sum[3] >> 2;
      p.valid = 1'b1;
      return p;
    endfunction

    function void note_item(item_t it);
      case (it.op)
        OP_PAL_WR: begin
          palette[it.pal_idx] = {it.blue, it.green, it.red};
          pal_written[it.pal_idx] = 1;
          writes++;
        end
        OP_TEX_WR: begin
          texels[it.tex_addr] = it.tex_idx;
          tex_written[it.tex_addr] = 1;
          writes++;
        end
        OP_FETCH: begin
          pending.push_back(resample(it.fx, it.fy));
          fetches++;
        end
        default: ;
      endcase
    endfunction

    function void cmp(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_pixel(pixel_t act);
      pixel_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, got red %0d", $time, act.red);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      cmp("pixel_red", e.red, act.red);
      cmp("pixel_green", e.green, act.green);
      cmp("pixel_blue", e.blue, act.blue);
      cmp("pixel_alpha", e.alpha, act.alpha);
      cmp("output_width", e.out_w, act.out_w);
      cmp("output_height", e.out_h, act.out_h);
      cmp("fetch_valid", e.valid, act.valid);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i, in_valid_i, in_stall_o, out_valid_o, out_stall_i, fetch_valid_o;
  logic [1:0] cfg_index_i, operation_i;
  logic [8:0] cfg_data_i, output_width_o, output_height_o;
  logic [7:0] palette_index_i, entry_red_i, entry_green_i, entry_blue_i;
  logic [7:0] texel_index_i, fetch_x_i, fetch_y_i;
  logic [15:0] texel_address_i;
  logic [7:0] pixel_red_o, pixel_green_o, pixel_blue_o, pixel_alpha_o;

  int send_idle_pct;
  int recv_stall_pct;
  int sent_items;
  pixel_scoreboard sb;

  always #1 clk_i = ~clk_i;

  palette_texture_resample u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .operation_i, .palette_index_i,
    .entry_red_i, .entry_green_i, .entry_blue_i, .texel_address_i,
    .texel_index_i, .fetch_x_i, .fetch_y_i, .out_valid_o, .out_stall_i,
    .pixel_red_o, .pixel_green_o, .pixel_blue_o, .pixel_alpha_o,
    .output_width_o, .output_height_o, .fetch_valid_o
  );

  // Result side: check accepted results, stall at random.
  always @(posedge clk_i) begin
    pixel_t act;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      act.red = pixel_red_o;
      act.green = pixel_green_o;
      act.blue = pixel_blue_o;
      act.alpha = pixel_alpha_o;
      act.out_w = output_width_o;
      act.out_h = output_height_o;
      act.valid = fetch_valid_o;
      sb.check_pixel(act);
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_item(item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= it.op;
    palette_index_i <= it.pal_idx;
    entry_red_i <= it.red;
    entry_green_i <= it.green;
    entry_blue_i <= it.blue;
    texel_address_i <= it.tex_addr;
    texel_index_i <= it.tex_idx;
    fetch_x_i <= it.fx;
    fetch_y_i <= it.fy;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(it);
    sent_items++;
  endtask

  function automatic item_t rand_item(logic [1:0] op);
    item_t it;
    it.op = op;
    it.pal_idx = $urandom;
    it.red = $urandom;
    it.green = $urandom;
    it.blue = $urandom;
    it.tex_addr = $urandom;
    it.tex_idx = $urandom;
    it.fx = $urandom;
    it.fy = $urandom;
    return it;
  endfunction

  task automatic write_palette(logic [7:0] idx);
    item_t it;
    it = rand_item(OP_PAL_WR);
    it.pal_idx = idx;
    send_item(it);
  endtask

  // Fill any unwritten texel or palette entry that the fetch would read, then fetch.
  task automatic fetch_pixel(logic [7:0] x, logic [7:0] y);
    item_t it;
    int a [4];
    sb.tap_addrs(x, y, a);
    foreach (a[k]) begin
      if (a[k] >= 0 && !sb.tex_written[a[k]]) begin
        it = rand_item(OP_TEX_WR);
        it.tex_addr = a[k];
        if ($urandom_range(9) == 0) it.tex_idx = KEY_INDEX;
        send_item(it);
      end
      if (a[k] >= 0 && !sb.pal_written[sb.texels[a[k]]])
        write_palette(sb.texels[a[k]]);
    end
    it = rand_item(OP_FETCH);
    it.fx = x;
    it.fy = y;
    send_item(it);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [8:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  // Send about n items, counting the fill writes that fetches bring along.
  task automatic random_items(int n);
    item_t it;
    int ow, oh;
    int stop;
    stop = sent_items + n;
    while (sent_items < stop) begin
      ow = sb.pow2_dim(sb.clamp_dim(sb.src_w));
      oh = sb.pow2_dim(sb.clamp_dim(sb.src_h));
      case ($urandom_range(19))
        0, 1, 2: begin
          it = rand_item(OP_PAL_WR);
          send_item(it);
        end
        3, 4, 5: begin
          it = rand_item(OP_TEX_WR);
          send_item(it);
        end
        6: begin
          it = rand_item(OP_NONE);
          send_item(it);
        end
        7, 8: fetch_pixel($urandom, $urandom);
        default: fetch_pixel($urandom_range(ow - 1), $urandom_range(oh - 1));
      endcase
    end
  endtask

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    item_t it;
    int w_set [10] = '{16, 256, 1, 0, 511, 3, 200, 17, 9, 64};
    int h_set [10] = '{16, 256, 1, 0, 300, 5, 33, 128, 256, 2};
    sb = new();
    sent_items = 0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    operation_i = OP_NONE;
    palette_index_i = '0;
    entry_red_i = '0;
    entry_green_i = '0;
    entry_blue_i = '0;
    texel_address_i = '0;
    texel_index_i = '0;
    fetch_x_i = '0;
    fetch_y_i = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes on the reset configuration.
    it = rand_item(OP_PAL_WR);
    it.pal_idx = 8'd0;
    {it.red, it.green, it.blue} = '0;
    send_item(it);
    it.pal_idx = KEY_INDEX;
    {it.red, it.green, it.blue} = '1;
    send_item(it);
    it = rand_item(OP_TEX_WR);
    it.tex_addr = 16'd0;
    it.tex_idx = KEY_INDEX;
    send_item(it);
    it.tex_addr = 16'hFFFF;
    it.tex_idx = 8'd0;
    send_item(it);
    it = rand_item(OP_NONE);
    it = '{OP_NONE, '1, '1, '1, '1, '1, '1, '1, '1};
    send_item(it);
    fetch_pixel(8'd0, 8'd0);
    fetch_pixel(8'd15, 8'd15);
    fetch_pixel(8'd16, 8'd0);
    fetch_pixel(8'd255, 8'd255);
    drain();
    write_reg(REG_NONE, 9'h1FF);
    write_reg(REG_PAL_FORMAT, {7'd0, FMT_ALPHA_TEST});
    fetch_pixel(8'd0, 8'd0);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      write_reg(REG_SRC_WIDTH, w_set[ph]);
      write_reg(REG_SRC_HEIGHT, h_set[ph]);
      write_reg(REG_PAL_FORMAT, ph % 4);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      // Corner pixels of the output first.
      fetch_pixel(8'd0, 8'd0);
      fetch_pixel(sb.pow2_dim(sb.clamp_dim(sb.src_w)) - 1,
                  sb.pow2_dim(sb.clamp_dim(sb.src_h)) - 1);
      random_items(100);
      drain();
    end

    $display("Covered %0d fetches and %0d store writes over 10 size/format settings,",
             sb.fetches, sb.writes);
    $display("%0d results checked, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
